// ===== design/scp_pkg.sv =====
`timescale 1ns / 1ps

package scp_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned NumMethods = 14;
  localparam int unsigned NameBits   = 80;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_LEADWS = 3'd1,
    PH_NUMBER = 3'd2,
    PH_NUMLWS = 3'd3,
    PH_METHOD = 3'd4,
    PH_METHWS = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SYNTAX    = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_METHOD    = 3'd3,
    ST_UNHANDLED = 3'd4
  } status_e;

  localparam logic [3:0] M_INVITE    = 4'd0;
  localparam logic [3:0] M_ACK       = 4'd1;
  localparam logic [3:0] M_BYE       = 4'd2;
  localparam logic [3:0] M_CANCEL    = 4'd3;
  localparam logic [3:0] M_REGISTER  = 4'd4;
  localparam logic [3:0] M_OPTIONS   = 4'd5;
  localparam logic [3:0] M_PRACK     = 4'd6;
  localparam logic [3:0] M_SUBSCRIBE = 4'd7;
  localparam logic [3:0] M_NOTIFY    = 4'd8;
  localparam logic [3:0] M_PUBLISH   = 4'd9;
  localparam logic [3:0] M_INFO      = 4'd10;
  localparam logic [3:0] M_REFER     = 4'd11;
  localparam logic [3:0] M_MESSAGE   = 4'd12;
  localparam logic [3:0] M_UPDATE    = 4'd13;
  localparam logic [3:0] M_NONE      = 4'd15;

  localparam logic [7:0] ChZero  = "0";
  localparam logic [7:0] ChNine  = "9";
  localparam logic [7:0] ChUpA   = "A";
  localparam logic [7:0] ChUpZ   = "Z";
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChV     = "V";
  localparam logic [7:0] ChU     = "U";
  localparam logic [7:0] ChG     = "G";

  // right-justified names, first character in the highest occupied byte
  localparam logic [NameBits-1:0] MethodName [NumMethods] = '{
    NameBits'("INVITE"), NameBits'("ACK"), NameBits'("BYE"), NameBits'("CANCEL"),
    NameBits'("REGISTER"), NameBits'("OPTIONS"), NameBits'("PRACK"),
    NameBits'("SUBSCRIBE"), NameBits'("NOTIFY"), NameBits'("PUBLISH"),
    NameBits'("INFO"), NameBits'("REFER"), NameBits'("MESSAGE"), NameBits'("UPDATE")
  };

  localparam logic [3:0] MethodLen [NumMethods] = '{
    4'd6, 4'd3, 4'd3, 4'd6, 4'd8, 4'd7, 4'd5, 4'd9, 4'd6, 4'd7, 4'd4, 4'd5, 4'd7, 4'd6
  };

  function automatic logic [7:0] rom_char(logic [3:0] m, logic [3:0] i);
    logic [3:0] len;
    logic [3:0] rem;
    logic [6:0] base;
    logic [7:0] ch;
    ch = 8'h00;
    if (m < 4'(NumMethods)) begin
      len = MethodLen[m];
      if (i < len) begin
        rem  = len - 4'd1 - i;
        base = {rem, 3'b000};
        ch   = MethodName[m][base +: 8];
      end
    end
    return ch;
  endfunction

  function automatic logic name_done(logic [3:0] m, logic [3:0] i);
    logic res;
    res = 1'b1;
    if (m < 4'(NumMethods)) begin
      res = (i >= MethodLen[m]);
    end
    return res;
  endfunction

  function automatic logic [3:0] first_letter(logic [7:0] c);
    logic [3:0] code;
    case (c)
      "A":     code = M_ACK;
      "B":     code = M_BYE;
      "C":     code = M_CANCEL;
      "I":     code = M_INFO;
      "M":     code = M_MESSAGE;
      "N":     code = M_NOTIFY;
      "O":     code = M_OPTIONS;
      "P":     code = M_PRACK;
      "R":     code = M_REFER;
      "S":     code = M_SUBSCRIBE;
      "U":     code = M_UPDATE;
      default: code = M_NONE;
    endcase
    return code;
  endfunction

endpackage

// ===== design/scp_if.sv =====
`timescale 1ns / 1ps

interface scp_in_if #(
  parameter int unsigned OFFSET_BITS = scp_pkg::OffsetBits
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic [OFFSET_BITS-1:0] first_position;
  logic                   last_byte;

  modport source(output valid, data_byte, first_position, last_byte, input ready);
  modport sink(input valid, data_byte, first_position, last_byte, output ready);
endinterface

interface scp_out_if #(
  parameter int unsigned OFFSET_BITS = scp_pkg::OffsetBits
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [31:0]            sequence_number;
  logic [OFFSET_BITS-1:0] number_start;
  logic [OFFSET_BITS-1:0] number_length;
  logic [3:0]             method_code;
  logic [OFFSET_BITS-1:0] method_start;
  logic [OFFSET_BITS-1:0] method_length;

  modport source(output valid, status, sequence_number, number_start, number_length,
                 method_code, method_start, method_length, input ready);
  modport sink(input valid, status, sequence_number, number_start, number_length,
               method_code, method_start, method_length, output ready);
endinterface

// ===== design/scp_parse_core.sv =====
`timescale 1ns / 1ps

module scp_parse_core #(
  parameter int unsigned OFFSET_BITS = scp_pkg::OffsetBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic [7:0]             data_byte_i,
  input  logic [OFFSET_BITS-1:0] first_position_i,
  input  logic                   last_byte_i,
  output logic                   res_valid_o,
  output logic [2:0]             status_o,
  output logic [31:0]            sequence_number_o,
  output logic [OFFSET_BITS-1:0] number_start_o,
  output logic [OFFSET_BITS-1:0] number_length_o,
  output logic [3:0]             method_code_o,
  output logic [OFFSET_BITS-1:0] method_start_o,
  output logic [OFFSET_BITS-1:0] method_length_o
);

  scp_pkg::phase_e        phase_q, phase_d;
  logic [31:0]            acc_q, acc_d;
  logic [3:0]             cand_q, cand_d;
  logic [3:0]             midx_q, midx_d;
  logic [OFFSET_BITS-1:0] bpos_q, bpos_d;
  logic [OFFSET_BITS-1:0] nstart_q, nstart_d;
  logic [OFFSET_BITS-1:0] nlen_q, nlen_d;
  logic [OFFSET_BITS-1:0] mstart_q, mstart_d;
  logic [OFFSET_BITS-1:0] mlen_q, mlen_d;
  logic                   skip_q, skip_d;

  scp_pkg::status_e       err;
  logic [OFFSET_BITS-1:0] pos;
  logic [3:0]             dig;
  logic [35:0]            acc10;
  logic [7:0]             want;
  logic [3:0]             fl_code;
  logic                   is_dec, is_lws, is_sp, is_upper;
  logic                   clear;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(logic [OFFSET_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_comb begin
    dig      = 4'(data_byte_i - scp_pkg::ChZero);
    acc10    = 36'({acc_q, 3'b000}) + 36'({acc_q, 1'b0}) + 36'(dig);
    want     = scp_pkg::rom_char(cand_q, midx_q);
    fl_code  = scp_pkg::first_letter(data_byte_i);
    is_dec   = (data_byte_i inside {[scp_pkg::ChZero : scp_pkg::ChNine]});
    is_upper = (data_byte_i inside {[scp_pkg::ChUpA : scp_pkg::ChUpZ]});
    is_sp    = (data_byte_i inside {scp_pkg::ChSpace, scp_pkg::ChTab});
    is_lws   = (data_byte_i inside {scp_pkg::ChSpace, scp_pkg::ChTab,
                                    scp_pkg::ChCr, scp_pkg::ChLf});
    pos      = (phase_q == scp_pkg::PH_START) ? first_position_i : bpos_q;

    phase_d  = phase_q;
    acc_d    = acc_q;
    cand_d   = cand_q;
    midx_d   = midx_q;
    bpos_d   = bpos_q;
    nstart_d = nstart_q;
    nlen_d   = nlen_q;
    mstart_d = mstart_q;
    mlen_d   = mlen_q;
    skip_d   = skip_q;
    err      = scp_pkg::ST_OK;
    clear    = 1'b0;
    res_valid_o = 1'b0;
    status_o    = scp_pkg::ST_OK;

    if (take_i) begin
      bpos_d = pos + 1'b1;
      if (skip_q) begin
        clear = last_byte_i;
      end else begin
        case (phase_q)
          scp_pkg::PH_START, scp_pkg::PH_LEADWS: begin
            if (is_dec) begin
              acc_d    = 32'(dig);
              nstart_d = pos;
              nlen_d   = OFFSET_BITS'(1);
              phase_d  = scp_pkg::PH_NUMBER;
            end else if (is_lws) begin
              phase_d = scp_pkg::PH_LEADWS;
            end else begin
              err = scp_pkg::ST_SYNTAX;
            end
          end
          scp_pkg::PH_NUMBER: begin
            if (is_dec) begin
              if (acc10[35:32] != 4'd0) begin
                err = scp_pkg::ST_OVERFLOW;
              end else begin
                acc_d  = acc10[31:0];
                nlen_d = sat_inc(nlen_q);
              end
            end else if (is_lws) begin
              phase_d = scp_pkg::PH_NUMLWS;
            end else begin
              err = scp_pkg::ST_SYNTAX;
            end
          end
          scp_pkg::PH_NUMLWS: begin
            if (is_lws) begin
              phase_d = scp_pkg::PH_NUMLWS;
            end else if (is_upper) begin
              phase_d  = scp_pkg::PH_METHOD;
              mstart_d = pos;
              mlen_d   = OFFSET_BITS'(1);
              midx_d   = 4'd1;
              cand_d   = scp_pkg::M_INVITE;
              if (fl_code == scp_pkg::M_NONE) begin
                err = scp_pkg::ST_METHOD;
              end else begin
                cand_d = fl_code;
              end
            end else begin
              err = scp_pkg::ST_SYNTAX;
            end
          end
          scp_pkg::PH_METHOD: begin
            if (is_upper) begin
              mlen_d = sat_inc(mlen_q);
              if (want != data_byte_i) begin
                if (cand_q == scp_pkg::M_INFO && midx_q == 4'd2 &&
                    data_byte_i == scp_pkg::ChV) begin
                  cand_d = scp_pkg::M_INVITE;
                end else if (cand_q == scp_pkg::M_PRACK && midx_q == 4'd1 &&
                             data_byte_i == scp_pkg::ChU) begin
                  cand_d = scp_pkg::M_PUBLISH;
                end else if (cand_q == scp_pkg::M_REFER && midx_q == 4'd2 &&
                             data_byte_i == scp_pkg::ChG) begin
                  cand_d = scp_pkg::M_REGISTER;
                end else begin
                  err = scp_pkg::ST_METHOD;
                end
              end
              if (err == scp_pkg::ST_OK) begin
                midx_d = midx_q + 4'd1;
              end
            end else if (is_sp) begin
              phase_d = scp_pkg::PH_METHWS;
            end else begin
              err = scp_pkg::ST_SYNTAX;
            end
          end
          scp_pkg::PH_METHWS: begin
            if (!is_sp) begin
              err = scp_pkg::ST_SYNTAX;
            end
          end
          default: begin
            err = scp_pkg::ST_SYNTAX;
          end
        endcase

        if (err != scp_pkg::ST_OK) begin
          res_valid_o = 1'b1;
          status_o    = err;
          if (last_byte_i) begin
            clear = 1'b1;
          end else begin
            skip_d = 1'b1;
          end
        end else if (last_byte_i) begin
          res_valid_o = 1'b1;
          clear       = 1'b1;
          if (phase_d == scp_pkg::PH_METHOD || phase_d == scp_pkg::PH_METHWS) begin
            status_o = scp_pkg::name_done(cand_d, midx_d) ? scp_pkg::ST_OK
                                                          : scp_pkg::ST_METHOD;
          end else begin
            status_o = scp_pkg::ST_UNHANDLED;
          end
        end
      end
    end

    sequence_number_o = acc_d;
    number_start_o    = nstart_d;
    number_length_o   = nlen_d;
    method_code_o     = cand_d;
    method_start_o    = mstart_d;
    method_length_o   = mlen_d;

    if (clear) begin
      phase_d  = scp_pkg::PH_START;
      acc_d    = '0;
      cand_d   = '0;
      midx_d   = '0;
      bpos_d   = '0;
      nstart_d = '0;
      nlen_d   = '0;
      mstart_d = '0;
      mlen_d   = '0;
      skip_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= scp_pkg::PH_START;
      acc_q    <= '0;
      cand_q   <= '0;
      midx_q   <= '0;
      bpos_q   <= '0;
      nstart_q <= '0;
      nlen_q   <= '0;
      mstart_q <= '0;
      mlen_q   <= '0;
      skip_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      cand_q   <= cand_d;
      midx_q   <= midx_d;
      bpos_q   <= bpos_d;
      nstart_q <= nstart_d;
      nlen_q   <= nlen_d;
      mstart_q <= mstart_d;
      mlen_q   <= mlen_d;
      skip_q   <= skip_d;
    end
  end

  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> !res_valid_o)
    else $error("result emitted while dropping the rest of a header");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && last_byte_i |=> phase_q == scp_pkg::PH_START && !skip_q && bpos_q == '0)
    else $error("parser not restarted after last byte");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && last_byte_i && !skip_q |-> res_valid_o)
    else $error("header ended without a result");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    midx_q <= 4'd9)
    else $error("method match index past longest name");

endmodule

// ===== design/scp_skid_fifo.sv =====
`timescale 1ns / 1ps

module scp_skid_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== design/sip_cseq_header_parser.sv =====
`timescale 1ns / 1ps
// A result enters the registered output queue as the byte that decides it is taken.
// Throughput: one byte per cycle while the queue has room; the parse state updates
// in a single registered pass. The two-entry output queue keeps cseq_i ready while one
// finished result waits. Reset (rst_ni low, asynchronous) returns the parser to the
// start of a header and empties the output queue; no clearing pass is needed.

module sip_cseq_header_parser #(
  parameter int unsigned OFFSET_BITS = scp_pkg::OffsetBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  scp_in_if.sink   cseq_i,
  scp_out_if.source result_o
);

  localparam int unsigned ResW = 3 + 32 + 4 + 4 * OFFSET_BITS;

  logic                   take;
  logic                   res_valid;
  logic [2:0]             status;
  logic [31:0]            seq_num;
  logic [OFFSET_BITS-1:0] num_start, num_len, meth_start, meth_len;
  logic [3:0]             meth_code;
  logic                   space;
  logic [ResW-1:0]        push_data, pop_data;

  assign cseq_i.ready = space;
  assign take         = cseq_i.valid && space;

  scp_parse_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .data_byte_i      (cseq_i.data_byte),
    .first_position_i (cseq_i.first_position),
    .last_byte_i      (cseq_i.last_byte),
    .res_valid_o      (res_valid),
    .status_o         (status),
    .sequence_number_o(seq_num),
    .number_start_o   (num_start),
    .number_length_o  (num_len),
    .method_code_o    (meth_code),
    .method_start_o   (meth_start),
    .method_length_o  (meth_len)
  );

  assign push_data = {status, seq_num, num_start, num_len, meth_code, meth_start, meth_len};

  scp_skid_fifo #(
    .WIDTH(ResW)
  ) u_out_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(push_data),
    .space_o    (space),
    .valid_o    (result_o.valid),
    .ready_i    (result_o.ready),
    .data_o     (pop_data)
  );

  assign {result_o.status, result_o.sequence_number, result_o.number_start,
          result_o.number_length, result_o.method_code, result_o.method_start,
          result_o.method_length} = pop_data;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    scp_pkg::status_e status;
    logic [31:0]      sequence_number;
    logic [15:0]      number_start;
    logic [15:0]      number_length;
    logic [3:0]       method_code;
    logic [15:0]      method_start;
    logic [15:0]      method_length;
  } cseq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  scp_in_if  cseq_if ();
  scp_out_if result_if ();

  sip_cseq_header_parser DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cseq_i  (cseq_if),
    .result_o(result_if)
  );

  string method_names [14] = '{
    "INVITE", "ACK", "BYE", "CANCEL", "REGISTER", "OPTIONS", "PRACK",
    "SUBSCRIBE", "NOTIFY", "PUBLISH", "INFO", "REFER", "MESSAGE", "UPDATE"
  };

  cseq_result_t expected_results[$];
  int unsigned  mismatches;
  int unsigned  sent_bytes;
  int unsigned  rx_wait;
  bit           tx_gaps_on;
  bit           rx_gaps_on;

  scp_pkg::phase_e cur_phase;
  logic [31:0]     seq_value;
  logic [3:0]      cand_method;
  logic [3:0]      name_index;
  logic [15:0]     next_offset;
  logic [15:0]     num_start;
  logic [15:0]     num_len;
  logic [15:0]     meth_start;
  logic [15:0]     meth_len;
  bit              swallowing;

  function automatic void clear_parser();
    cur_phase   = scp_pkg::PH_START;
    seq_value   = '0;
    cand_method = '0;
    name_index  = '0;
    next_offset = '0;
    num_start   = '0;
    num_len     = '0;
    meth_start  = '0;
    meth_len    = '0;
    swallowing  = 1'b0;
  endfunction

  function automatic logic [7:0] name_char(logic [3:0] m, logic [3:0] i);
    if (m < 4'(scp_pkg::NumMethods) && i < method_names[m].len()) return method_names[m][i];
    return 8'h00;
  endfunction

  function automatic logic [3:0] letter_to_method(logic [7:0] c);
    case (c)
      "A":     return scp_pkg::M_ACK;
      "B":     return scp_pkg::M_BYE;
      "C":     return scp_pkg::M_CANCEL;
      "I":     return scp_pkg::M_INFO;
      "M":     return scp_pkg::M_MESSAGE;
      "N":     return scp_pkg::M_NOTIFY;
      "O":     return scp_pkg::M_OPTIONS;
      "P":     return scp_pkg::M_PRACK;
      "R":     return scp_pkg::M_REFER;
      "S":     return scp_pkg::M_SUBSCRIBE;
      "U":     return scp_pkg::M_UPDATE;
      default: return scp_pkg::M_NONE;
    endcase
  endfunction

  function automatic bit is_lws(logic [7:0] c);
    return c == scp_pkg::ChSpace || c == scp_pkg::ChTab ||
           c == scp_pkg::ChCr || c == scp_pkg::ChLf;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == scp_pkg::ChSpace || c == scp_pkg::ChTab;
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return c >= scp_pkg::ChZero && c <= scp_pkg::ChNine;
  endfunction

  function automatic bit is_upper(logic [7:0] c);
    return c >= scp_pkg::ChUpA && c <= scp_pkg::ChUpZ;
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic scp_pkg::status_e parse_char(logic [7:0] c, logic [15:0] pos);
    logic [35:0] product;
    logic [3:0]  m;
    logic [7:0]  want;
    case (cur_phase)
      scp_pkg::PH_START, scp_pkg::PH_LEADWS: begin
        if (is_dec(c)) begin
          seq_value = 32'(c - scp_pkg::ChZero);
          num_start = pos;
          num_len   = 16'd1;
          cur_phase = scp_pkg::PH_NUMBER;
          return scp_pkg::ST_OK;
        end
        if (is_lws(c)) begin
          cur_phase = scp_pkg::PH_LEADWS;
          return scp_pkg::ST_OK;
        end
        return scp_pkg::ST_SYNTAX;
      end
      scp_pkg::PH_NUMBER: begin
        if (is_dec(c)) begin
          product = 36'(seq_value) * 36'd10 + 36'(c - scp_pkg::ChZero);
          if (product[35:32] != 4'd0) return scp_pkg::ST_OVERFLOW;
          seq_value = product[31:0];
          num_len   = sat_inc(num_len);
          return scp_pkg::ST_OK;
        end
        if (is_lws(c)) begin
          cur_phase = scp_pkg::PH_NUMLWS;
          return scp_pkg::ST_OK;
        end
        return scp_pkg::ST_SYNTAX;
      end
      scp_pkg::PH_NUMLWS: begin
        if (is_lws(c)) return scp_pkg::ST_OK;
        if (is_upper(c)) begin
          m           = letter_to_method(c);
          cur_phase   = scp_pkg::PH_METHOD;
          meth_start  = pos;
          meth_len    = 16'd1;
          name_index  = 4'd1;
          cand_method = scp_pkg::M_INVITE;
          if (m == scp_pkg::M_NONE) return scp_pkg::ST_METHOD;
          cand_method = m;
          return scp_pkg::ST_OK;
        end
        return scp_pkg::ST_SYNTAX;
      end
      scp_pkg::PH_METHOD: begin
        if (is_upper(c)) begin
          want     = name_char(cand_method, name_index);
          meth_len = sat_inc(meth_len);
          if (want != c) begin
            if (cand_method == scp_pkg::M_INFO && name_index == 4'd2 &&
                c == scp_pkg::ChV) begin
              cand_method = scp_pkg::M_INVITE;
            end else if (cand_method == scp_pkg::M_PRACK && name_index == 4'd1 &&
                         c == scp_pkg::ChU) begin
              cand_method = scp_pkg::M_PUBLISH;
            end else if (cand_method == scp_pkg::M_REFER && name_index == 4'd2 &&
                         c == scp_pkg::ChG) begin
              cand_method = scp_pkg::M_REGISTER;
            end else begin
              return scp_pkg::ST_METHOD;
            end
          end
          name_index = name_index + 4'd1;
          return scp_pkg::ST_OK;
        end
        if (is_blank(c)) begin
          cur_phase = scp_pkg::PH_METHWS;
          return scp_pkg::ST_OK;
        end
        return scp_pkg::ST_SYNTAX;
      end
      scp_pkg::PH_METHWS: begin
        if (is_blank(c)) return scp_pkg::ST_OK;
        return scp_pkg::ST_SYNTAX;
      end
      default: return scp_pkg::ST_SYNTAX;
    endcase
  endfunction

  function automatic void push_result(scp_pkg::status_e st);
    cseq_result_t r;
    r.status          = st;
    r.sequence_number = seq_value;
    r.number_start    = num_start;
    r.number_length   = num_len;
    r.method_code     = cand_method;
    r.method_start    = meth_start;
    r.method_length   = meth_len;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_byte(logic [7:0] c, logic [15:0] fp, logic last);
    logic [15:0]      pos;
    scp_pkg::status_e st;
    sent_bytes++;
    pos         = (cur_phase == scp_pkg::PH_START) ? fp : next_offset;
    next_offset = pos + 16'd1;
    if (swallowing) begin
      if (last) clear_parser();
      return;
    end
    st = parse_char(c, pos);
    if (st != scp_pkg::ST_OK) begin
      push_result(st);
      if (last) clear_parser();
      else swallowing = 1'b1;
      return;
    end
    if (!last) return;
    if (cur_phase == scp_pkg::PH_METHOD || cur_phase == scp_pkg::PH_METHWS) begin
      st = (name_char(cand_method, name_index) == 8'h00) ? scp_pkg::ST_OK
                                                         : scp_pkg::ST_METHOD;
    end else begin
      st = scp_pkg::ST_UNHANDLED;
    end
    push_result(st);
    clear_parser();
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    cseq_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no transaction pending: status %0d", result_if.status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(result_if.status));
        check_field("sequence_number", want.sequence_number, result_if.sequence_number);
        check_field("number_start", 32'(want.number_start), 32'(result_if.number_start));
        check_field("number_length", 32'(want.number_length), 32'(result_if.number_length));
        check_field("method_code", 32'(want.method_code), 32'(result_if.method_code));
        check_field("method_start", 32'(want.method_start), 32'(result_if.method_start));
        check_field("method_length", 32'(want.method_length),
                    32'(result_if.method_length));
      end
      rx_wait = rx_gaps_on ? $urandom_range(0, 4) : 0;
    end
    if (rx_wait > 0) begin
      result_if.ready <= 1'b0;
      rx_wait--;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic [15:0] fp, input logic last);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      cseq_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cseq_if.valid          <= 1'b1;
    cseq_if.data_byte      <= c;
    cseq_if.first_position <= fp;
    cseq_if.last_byte      <= last;
    do @(posedge clk_i); while (!cseq_if.ready);
    predict_byte(c, fp, last);
  endtask

  task automatic send_header(input byte_q_t text, input logic [15:0] fp);
    for (int i = 0; i < text.size(); i++) begin
      send_byte(text[i], (i == 0) ? fp : 16'($urandom), i == text.size() - 1);
    end
  endtask

  task automatic send_text(input string s, input logic [15:0] fp);
    byte_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_header(text, fp);
  endtask

  task automatic wait_results_drained();
    cseq_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] lws_char();
    case ($urandom_range(0, 3))
      0:       return scp_pkg::ChSpace;
      1:       return scp_pkg::ChTab;
      2:       return scp_pkg::ChCr;
      default: return scp_pkg::ChLf;
    endcase
  endfunction

  function automatic logic [7:0] upper_char();
    return 8'(scp_pkg::ChUpA + $urandom_range(0, 25));
  endfunction

  function automatic byte_q_t make_header();
    byte_q_t     q;
    string       txt;
    int unsigned kind;
    int unsigned cut;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      return q;
    end
    repeat ($urandom_range(0, 2)) q.push_back(lws_char());
    case ($urandom_range(0, 9))
      0:       txt = "4294967295";
      1:       txt = $sformatf("429496729%0d", $urandom_range(5, 9));
      2:       txt = $sformatf("%0d%0d", $urandom_range(1, 99999),
                               $urandom_range(100000, 999999));
      3:       txt = $sformatf("0%0d", $urandom_range(0, 999));
      default: txt = $sformatf("%0d", $urandom_range(0, 99999999));
    endcase
    for (int i = 0; i < txt.len(); i++) q.push_back(txt[i]);
    repeat ($urandom_range(1, 2)) q.push_back(lws_char());
    txt = method_names[$urandom_range(0, scp_pkg::NumMethods - 1)];
    case ($urandom_range(0, 7))
      0: txt = txt.substr(0, $urandom_range(0, txt.len() - 2));
      1: txt = $sformatf("%s%c", txt, upper_char());
      2: begin
        cut      = $urandom_range(1, txt.len() - 1);
        txt[cut] = upper_char();
      end
      default: ;
    endcase
    for (int i = 0; i < txt.len(); i++) q.push_back(txt[i]);
    repeat ($urandom_range(0, 2)) begin
      q.push_back($urandom_range(0, 1) ? scp_pkg::ChSpace : scp_pkg::ChTab);
    end
    if (kind >= 7) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    return q;
  endfunction

  task automatic test_offset_wrap();
    send_text(" 7 ACK", 16'hFFFF);
  endtask

  task automatic test_overflow();
    send_text("4294967296", 16'h0000);
  endtask

  task automatic test_bad_method_letter();
    send_text("1\015XQ", 16'($urandom));
  endtask

  task automatic test_early_end();
    send_text("\n9", 16'($urandom));
  endtask

  task automatic test_renames();
    send_text("3 INVITE\t", 16'($urandom));
    send_text("12 PUBLISH", 16'($urandom));
    send_text("5\tREGISTER ", 16'($urandom));
  endtask

  task automatic test_random_headers(input int unsigned count);
    int unsigned stop;
    logic [15:0] fp;
    stop = sent_bytes + count;
    while (sent_bytes < stop) begin
      fp = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 15))
                                       : 16'($urandom);
      send_header(make_header(), fp);
    end
  endtask

  initial begin
    cseq_if.valid          = 1'b0;
    cseq_if.data_byte      = '0;
    cseq_if.first_position = '0;
    cseq_if.last_byte      = 1'b0;
    result_if.ready        = 1'b0;
    mismatches             = 0;
    sent_bytes             = 0;
    rx_wait                = 0;
    tx_gaps_on             = 1'b0;
    rx_gaps_on             = 1'b0;
    clear_parser();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_offset_wrap();
    test_overflow();
    test_bad_method_letter();
    test_early_end();
    test_renames();
    wait_results_drained();

    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    test_random_headers(800);
    wait_results_drained();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    test_random_headers(200);
    rx_gaps_on = 1'b1;
    test_random_headers(150);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b0;
    test_random_headers(100);

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
